/* hdl/tbp_pkg.sv */
// shared constants, codes and types of the top-k block table prefetch planner
package tbp_pkg;

    localparam int NUM_DOCS   = 256;
    localparam int DOC_W      = $clog2(NUM_DOCS);
    localparam int NUM_BLOCKS = 64;
    localparam int BLK_W      = $clog2(NUM_BLOCKS);
    localparam int VC_W       = $clog2(NUM_BLOCKS + 1);
    localparam int TOPK_MAX   = 16;
    localparam int TK_W       = $clog2(TOPK_MAX);
    localparam int TKC_W      = $clog2(TOPK_MAX + 1);

    // input item kinds
    typedef enum logic [1:0] {
        K_MAP    = 2'd0,
        K_CLEAR  = 2'd1,
        K_VICTIM = 2'd2,
        K_TOPK   = 2'd3
    } t_in_kind;

    // result item kinds
    typedef enum logic [1:0] {
        OK_RESIDENT = 2'd0,
        OK_LOAD     = 2'd1,
        OK_STATUS   = 2'd2
    } t_out_kind;

    // step sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_HIT_RD,
        S_HIT_EVAL,
        S_VIC_RD,
        S_VIC_EVAL,
        S_MAP_RD,
        S_MAP_WR,
        S_REBUILD,
        S_EMIT_PAIR,
        S_EMIT_LOAD,
        S_EMIT_STAT
    } t_state;

    // one result item
    typedef struct packed {
        t_out_kind        out_kind;
        logic [BLK_W-1:0] out_block;
        logic [DOC_W-1:0] out_doc;
        logic [TKC_W-1:0] resident_count;
        logic [VC_W-1:0]  victim_count;
        logic [TKC_W-1:0] unplaced_misses;
        logic             overflow;
        logic             last_result;
    } t_result;

endpackage

/* hdl/tbp_in_if.sv */
// input channel: valid, ready and one input item
interface tbp_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                kind;
    logic [tbp_pkg::DOC_W-1:0] doc_index;
    logic [tbp_pkg::BLK_W-1:0] block_id;
    logic                      end_of_step;

    modport source (output valid, kind, doc_index, block_id, end_of_step, input ready);
    modport sink   (input valid, kind, doc_index, block_id, end_of_step, output ready);
endinterface

/* hdl/tbp_out_if.sv */
// output channel: valid, ready and one result item
interface tbp_out_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                out_kind;
    logic [tbp_pkg::BLK_W-1:0] out_block;
    logic [tbp_pkg::DOC_W-1:0] out_doc;
    logic [tbp_pkg::TKC_W-1:0] resident_count;
    logic [tbp_pkg::VC_W-1:0]  victim_count;
    logic [tbp_pkg::TKC_W-1:0] unplaced_misses;
    logic                      overflow;
    logic                      last_result;

    modport source (output valid, out_kind, out_block, out_doc, resident_count,
                    victim_count, unplaced_misses, overflow, last_result, input ready);
    modport sink   (input valid, out_kind, out_block, out_doc, resident_count,
                    victim_count, unplaced_misses, overflow, last_result, output ready);
endinterface

/* hdl/tbp_ram.sv */
// simple dual-port synchronous ram, one write and one registered read per cycle
module tbp_ram #(
    parameter int DEPTH = tbp_pkg::NUM_BLOCKS,
    parameter int WIDTH = tbp_pkg::BLK_W,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/topk_block_table_prefetch.sv */
// top level: map memories, victim list memory and the step sequencer
//
//  channel   dir  payload                                         transfer
//  i_in      in   kind, doc_index, block_id, end_of_step          valid & ready
//  o_out     out  out_kind, out_block, out_doc, resident_count,   valid & ready
//                 victim_count, unplaced_misses, overflow, last_result
//
// items other than a closing top-k index are handled in the idle state and keep it idle.
// a closing index runs a step: a read state then an act state for each request, each
// victim walked and each load, then the 64-entry victim rebuild sweep, then the resident
// pairs, loads and status are emitted, each waiting while the output register is full.
// synchronous active-low reset clears all valid bits at once, no clearing pass.
// results wait in one output register; input is taken only between steps.
module topk_block_table_prefetch (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tbp_in_if.sink    i_in,
    tbp_out_if.source o_out
);

    localparam int ND  = tbp_pkg::NUM_DOCS;
    localparam int NB  = tbp_pkg::NUM_BLOCKS;
    localparam int TK  = tbp_pkg::TOPK_MAX;
    localparam int DW  = tbp_pkg::DOC_W;
    localparam int BW  = tbp_pkg::BLK_W;
    localparam int VW  = tbp_pkg::VC_W;
    localparam int TW  = tbp_pkg::TK_W;
    localparam int CW  = tbp_pkg::TKC_W;

    tbp_pkg::t_state  r_state, n_state;
    logic [ND-1:0]    r_ivalid, n_ivalid;
    logic [NB-1:0]    r_bvalid, n_bvalid;
    logic [NB-1:0]    r_inuse, n_inuse;
    logic [VW-1:0]    r_vic_len, n_vic_len;
    logic [VW-1:0]    r_vi, n_vi;
    logic [CW-1:0]    r_req_len, n_req_len;
    logic             r_dropped, n_dropped;
    logic [CW-1:0]    r_i, n_i;
    logic [CW-1:0]    r_npairs, n_npairs;
    logic [CW-1:0]    r_nmiss, n_nmiss;
    logic [CW-1:0]    r_nload, n_nload;
    logic [CW-1:0]    r_nused, n_nused;
    logic             r_out_valid, n_out_valid;
    tbp_pkg::t_result r_out, n_out;
    logic [DW-1:0]    r_cur_doc, n_cur_doc;
    logic [DW-1:0]    r_req_buf [TK];
    logic [DW-1:0]    n_req_buf [TK];
    logic [DW-1:0]    r_pidx [TK];
    logic [DW-1:0]    n_pidx [TK];
    logic [BW-1:0]    r_pblk [TK];
    logic [BW-1:0]    n_pblk [TK];
    logic [DW-1:0]    r_miss [TK];
    logic [DW-1:0]    n_miss [TK];
    logic [BW-1:0]    r_lblk [TK];
    logic [BW-1:0]    n_lblk [TK];

    // ram ports
    logic          i2b_we, b2i_we, vic_we;
    logic [DW-1:0] i2b_waddr, i2b_raddr, b2i_wdata, b2i_rdata;
    logic [BW-1:0] i2b_wdata, i2b_rdata, b2i_waddr, b2i_raddr;
    logic [BW-1:0] vic_waddr, vic_raddr, vic_wdata, vic_rdata;

    // sorted insert helpers
    logic [DW-1:0] w_ins_doc;
    logic [BW-1:0] w_ins_blk;
    logic [TK-1:0] w_lt, w_eq;
    logic          w_seen;
    logic [DW-1:0] w_ins_pidx [TK];
    logic [BW-1:0] w_ins_pblk [TK];
    logic          can_load;

    // index to block map
    tbp_ram #(.DEPTH(ND), .WIDTH(BW)) u_i2b (
        .i_clk(i_clk), .i_we(i2b_we), .i_waddr(i2b_waddr), .i_wdata(i2b_wdata),
        .i_raddr(i2b_raddr), .o_rdata(i2b_rdata)
    );

    // block to index map
    tbp_ram #(.DEPTH(NB), .WIDTH(DW)) u_b2i (
        .i_clk(i_clk), .i_we(b2i_we), .i_waddr(b2i_waddr), .i_wdata(b2i_wdata),
        .i_raddr(b2i_raddr), .o_rdata(b2i_rdata)
    );

    // ordered victim list
    tbp_ram #(.DEPTH(NB), .WIDTH(BW)) u_vic (
        .i_clk(i_clk), .i_we(vic_we), .i_waddr(vic_waddr), .i_wdata(vic_wdata),
        .i_raddr(vic_raddr), .o_rdata(vic_rdata)
    );

    assign can_load = !r_out_valid || o_out.ready;

    // candidate pair for insertion into the index-sorted resident list
    always_comb begin
        w_ins_doc = (r_state == tbp_pkg::S_HIT_EVAL) ? r_cur_doc : r_miss[r_nload[TW-1:0]];
        w_ins_blk = (r_state == tbp_pkg::S_HIT_EVAL) ? i2b_rdata : vic_rdata;
        for (int j = 0; j < TK; j++) begin
            w_lt[j] = (CW'(j) < r_npairs) && (r_pidx[j] < w_ins_doc);
            w_eq[j] = (CW'(j) < r_npairs) && (r_pidx[j] == w_ins_doc);
        end
        w_seen = |w_eq;
        w_ins_pidx[0] = w_lt[0] ? r_pidx[0] : w_ins_doc;
        w_ins_pblk[0] = w_lt[0] ? r_pblk[0] : w_ins_blk;
        for (int j = 1; j < TK; j++) begin
            if (w_lt[j]) begin
                w_ins_pidx[j] = r_pidx[j];
                w_ins_pblk[j] = r_pblk[j];
            end else if (w_lt[j-1]) begin
                w_ins_pidx[j] = w_ins_doc;
                w_ins_pblk[j] = w_ins_blk;
            end else begin
                w_ins_pidx[j] = r_pidx[j-1];
                w_ins_pblk[j] = r_pblk[j-1];
            end
        end
    end

    // next state and datapath
    always_comb begin
        n_state     = r_state;
        n_ivalid    = r_ivalid;
        n_bvalid    = r_bvalid;
        n_inuse     = r_inuse;
        n_vic_len   = r_vic_len;
        n_vi        = r_vi;
        n_req_len   = r_req_len;
        n_dropped   = r_dropped;
        n_i         = r_i;
        n_npairs    = r_npairs;
        n_nmiss     = r_nmiss;
        n_nload     = r_nload;
        n_nused     = r_nused;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        n_cur_doc   = r_cur_doc;
        n_req_buf   = r_req_buf;
        n_pidx      = r_pidx;
        n_pblk      = r_pblk;
        n_miss      = r_miss;
        n_lblk      = r_lblk;

        i2b_we    = 1'b0;
        i2b_waddr = i_in.doc_index;
        i2b_wdata = i_in.block_id;
        i2b_raddr = r_req_buf[r_i[TW-1:0]];
        b2i_we    = 1'b0;
        b2i_waddr = i_in.block_id;
        b2i_wdata = i_in.doc_index;
        b2i_raddr = r_lblk[r_i[TW-1:0]];
        vic_we    = 1'b0;
        vic_waddr = r_vic_len[BW-1:0];
        vic_wdata = i_in.block_id;
        vic_raddr = r_vi[BW-1:0];

        unique case (r_state)
            tbp_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    unique case (tbp_pkg::t_in_kind'(i_in.kind))
                        tbp_pkg::K_MAP: begin
                            i2b_we = 1'b1;
                            b2i_we = 1'b1;
                            n_ivalid[i_in.doc_index] = 1'b1;
                            n_bvalid[i_in.block_id]  = 1'b1;
                        end
                        tbp_pkg::K_CLEAR: begin
                            n_ivalid = '0;
                            n_bvalid = '0;
                        end
                        tbp_pkg::K_VICTIM: begin
                            if (r_vic_len < VW'(NB)) begin
                                vic_we    = 1'b1;
                                n_vic_len = r_vic_len + 1'b1;
                            end
                        end
                        tbp_pkg::K_TOPK: begin
                            if (r_req_len < CW'(TK)) begin
                                n_req_buf[r_req_len[TW-1:0]] = i_in.doc_index;
                                n_req_len = r_req_len + 1'b1;
                            end else begin
                                n_dropped = 1'b1;
                            end
                            if (i_in.end_of_step) begin
                                n_state  = tbp_pkg::S_HIT_RD;
                                n_i      = '0;
                                n_npairs = '0;
                                n_nmiss  = '0;
                                n_nload  = '0;
                                n_nused  = '0;
                                n_inuse  = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // look up each buffered request
            tbp_pkg::S_HIT_RD: begin
                if (r_i == r_req_len) begin
                    n_state = tbp_pkg::S_VIC_RD;
                    n_vi    = '0;
                end else begin
                    n_cur_doc = r_req_buf[r_i[TW-1:0]];
                    n_state   = tbp_pkg::S_HIT_EVAL;
                end
            end
            tbp_pkg::S_HIT_EVAL: begin
                if (r_ivalid[r_cur_doc]) begin
                    if (!r_inuse[i2b_rdata]) begin
                        n_inuse[i2b_rdata] = 1'b1;
                        n_nused = r_nused + 1'b1;
                    end
                    if (!w_seen) begin
                        n_pidx   = w_ins_pidx;
                        n_pblk   = w_ins_pblk;
                        n_npairs = r_npairs + 1'b1;
                    end
                end else begin
                    n_miss[r_nmiss[TW-1:0]] = r_cur_doc;
                    n_nmiss = r_nmiss + 1'b1;
                end
                n_i     = r_i + 1'b1;
                n_state = tbp_pkg::S_HIT_RD;
            end
            // walk victims for the misses
            tbp_pkg::S_VIC_RD: begin
                if (r_vi == r_vic_len || r_nload == r_nmiss) begin
                    n_state = tbp_pkg::S_MAP_RD;
                    n_i     = '0;
                end else begin
                    n_vi    = r_vi + 1'b1;
                    n_state = tbp_pkg::S_VIC_EVAL;
                end
            end
            tbp_pkg::S_VIC_EVAL: begin
                if (!r_inuse[vic_rdata]) begin
                    n_inuse[vic_rdata] = 1'b1;
                    n_nused = r_nused + 1'b1;
                    if (!w_seen && r_npairs < CW'(TK)) begin
                        n_pidx   = w_ins_pidx;
                        n_pblk   = w_ins_pblk;
                        n_npairs = r_npairs + 1'b1;
                    end
                    n_lblk[r_nload[TW-1:0]] = vic_rdata;
                    n_nload = r_nload + 1'b1;
                end
                n_state = tbp_pkg::S_VIC_RD;
            end
            // rewrite both maps for each load
            tbp_pkg::S_MAP_RD: begin
                if (r_i == r_nload) begin
                    n_state   = tbp_pkg::S_REBUILD;
                    n_vi      = '0;
                    n_vic_len = '0;
                end else begin
                    n_state = tbp_pkg::S_MAP_WR;
                end
            end
            tbp_pkg::S_MAP_WR: begin
                if (r_bvalid[r_lblk[r_i[TW-1:0]]]) begin
                    n_ivalid[b2i_rdata] = 1'b0;
                end
                n_ivalid[r_miss[r_i[TW-1:0]]] = 1'b1;
                n_bvalid[r_lblk[r_i[TW-1:0]]] = 1'b1;
                b2i_we    = 1'b1;
                b2i_waddr = r_lblk[r_i[TW-1:0]];
                b2i_wdata = r_miss[r_i[TW-1:0]];
                i2b_we    = 1'b1;
                i2b_waddr = r_miss[r_i[TW-1:0]];
                i2b_wdata = r_lblk[r_i[TW-1:0]];
                n_i       = r_i + 1'b1;
                n_state   = tbp_pkg::S_MAP_RD;
            end
            // sweep all blocks for the new victim list
            tbp_pkg::S_REBUILD: begin
                if (r_vi == VW'(NB)) begin
                    n_state = tbp_pkg::S_EMIT_PAIR;
                    n_i     = '0;
                end else begin
                    if (r_bvalid[r_vi[BW-1:0]] && !r_inuse[r_vi[BW-1:0]]) begin
                        vic_we    = 1'b1;
                        vic_wdata = r_vi[BW-1:0];
                        n_vic_len = r_vic_len + 1'b1;
                    end
                    n_vi = r_vi + 1'b1;
                end
            end
            // results
            tbp_pkg::S_EMIT_PAIR: begin
                if (r_i == r_npairs) begin
                    n_state = tbp_pkg::S_EMIT_LOAD;
                    n_i     = '0;
                end else if (can_load) begin
                    n_out           = '0;
                    n_out.out_kind  = tbp_pkg::OK_RESIDENT;
                    n_out.out_block = r_pblk[r_i[TW-1:0]];
                    n_out_valid     = 1'b1;
                    n_i             = r_i + 1'b1;
                end
            end
            tbp_pkg::S_EMIT_LOAD: begin
                if (r_i == r_nload) begin
                    n_state = tbp_pkg::S_EMIT_STAT;
                end else if (can_load) begin
                    n_out           = '0;
                    n_out.out_kind  = tbp_pkg::OK_LOAD;
                    n_out.out_block = r_lblk[r_i[TW-1:0]];
                    n_out.out_doc   = r_miss[r_i[TW-1:0]];
                    n_out_valid     = 1'b1;
                    n_i             = r_i + 1'b1;
                end
            end
            tbp_pkg::S_EMIT_STAT: begin
                if (can_load) begin
                    n_out                 = '0;
                    n_out.out_kind        = tbp_pkg::OK_STATUS;
                    n_out.resident_count  = r_nused;
                    n_out.victim_count    = r_vic_len;
                    n_out.unplaced_misses = r_nmiss - r_nload;
                    n_out.overflow        = r_dropped;
                    n_out.last_result     = 1'b1;
                    n_out_valid           = 1'b1;
                    n_req_len             = '0;
                    n_dropped             = 1'b0;
                    n_state               = tbp_pkg::S_IDLE;
                end
            end
            default: n_state = tbp_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tbp_pkg::S_IDLE;
            r_ivalid    <= '0;
            r_bvalid    <= '0;
            r_inuse     <= '0;
            r_vic_len   <= '0;
            r_vi        <= '0;
            r_req_len   <= '0;
            r_dropped   <= 1'b0;
            r_i         <= '0;
            r_npairs    <= '0;
            r_nmiss     <= '0;
            r_nload     <= '0;
            r_nused     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ivalid    <= n_ivalid;
            r_bvalid    <= n_bvalid;
            r_inuse     <= n_inuse;
            r_vic_len   <= n_vic_len;
            r_vi        <= n_vi;
            r_req_len   <= n_req_len;
            r_dropped   <= n_dropped;
            r_i         <= n_i;
            r_npairs    <= n_npairs;
            r_nmiss     <= n_nmiss;
            r_nload     <= n_nload;
            r_nused     <= n_nused;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_cur_doc <= n_cur_doc;
        r_req_buf <= n_req_buf;
        r_pidx    <= n_pidx;
        r_pblk    <= n_pblk;
        r_miss    <= n_miss;
        r_lblk    <= n_lblk;
    end

    // ports
    assign i_in.ready            = (r_state == tbp_pkg::S_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.out_kind        = r_out.out_kind;
    assign o_out.out_block       = r_out.out_block;
    assign o_out.out_doc         = r_out.out_doc;
    assign o_out.resident_count  = r_out.resident_count;
    assign o_out.victim_count    = r_out.victim_count;
    assign o_out.unplaced_misses = r_out.unplaced_misses;
    assign o_out.overflow        = r_out.overflow;
    assign o_out.last_result     = r_out.last_result;

`ifndef SYNTHESIS
    // loads never outrun misses
    a_load_le_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nload <= r_nmiss) else $error("more loads than misses");

    // resident list never exceeds the top-k buffer
    a_pairs_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_npairs <= CW'(TK)) else $error("resident list overrun");

    // status item is always the closing one
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.out_kind == tbp_pkg::OK_STATUS) |-> r_out.last_result)
        else $error("status without last flag");

    // step bookkeeping is cleared once the status is loaded
    a_step_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tbp_pkg::S_EMIT_STAT && can_load)
        |=> (r_req_len == '0 && !r_dropped && r_state == tbp_pkg::S_IDLE))
        else $error("step bookkeeping not cleared");
`endif

endmodule
